[hw/rtl/gfp_pkg.sv]
// Shared types and constants for the gain frame parser.
`timescale 1ns / 1ps
package gfp_pkg;

	// Frame length limit and the width of the byte counter that follows from it.
	localparam int MaxFrame = 31;
	localparam int CountW   = $clog2(MaxFrame + 1);

	localparam int GainW = 16;

	// ASCII codes the parser reacts to.
	localparam logic [7:0] CharCaret = 8'h5E;
	localparam logic [7:0] CharCr    = 8'h0D;
	localparam logic [7:0] CharLf    = 8'h0A;
	localparam logic [7:0] CharComma = 8'h2C;
	localparam logic [7:0] CharDot   = 8'h2E;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;

	typedef enum logic [1:0] {
		StatusGood    = 2'd0,
		StatusBadChar = 2'd1,
		StatusTooLong = 2'd2
	} gfp_status_t;

	// Control into the parse step: one byte and its strobe.
	typedef struct packed {
		logic       fire;
		logic [7:0] rx_byte;
	} gfp_step_in_t;

	// One closed frame, as the parse step reports it.
	typedef struct packed {
		logic               valid;
		gfp_status_t        frame_status;
		logic [GainW-1:0]   gain_p;
		logic [GainW-1:0]   gain_i;
		logic [GainW-1:0]   gain_d;
		logic               p_given;
		logic               i_given;
		logic               d_given;
	} gfp_result_t;

endpackage

[hw/rtl/gfp_if.sv]
// Valid/ready channels for received bytes and for parsed frame words.
`timescale 1ns / 1ps
interface gfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface gfp_result_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 frame_status;
	logic [gfp_pkg::GainW-1:0]  gain_p;
	logic [gfp_pkg::GainW-1:0]  gain_i;
	logic [gfp_pkg::GainW-1:0]  gain_d;
	logic                       p_given;
	logic                       i_given;
	logic                       d_given;

	modport source (output valid, output frame_status, output gain_p, output gain_i,
		output gain_d, output p_given, output i_given, output d_given, input ready);
	modport sink (input valid, input frame_status, input gain_p, input gain_i,
		input gain_d, input p_given, input i_given, input d_given, output ready);
endinterface

[hw/rtl/gfp_step.sv]
// Frame state and the per-byte parse step of the gain frame parser.
`timescale 1ns / 1ps
module gfp_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gfp_pkg::gfp_step_in_t step_in,
	output gfp_pkg::gfp_result_t  result
);
	import gfp_pkg::*;

	logic               in_frame_q, in_frame_d;
	logic [CountW-1:0]  char_count_q, char_count_d;
	logic [1:0]         sep_count_q, sep_count_d;
	logic               in_fraction_q, in_fraction_d;
	logic [GainW-1:0]   acc_q, acc_d;
	logic [GainW-1:0]   held_p_q, held_p_d;
	logic [GainW-1:0]   held_i_q, held_i_d;

	logic               finish;
	logic               accepted;
	gfp_status_t        status;
	logic [CountW:0]    count_next;
	logic [1:0]         sep_next;

	// Next state for one byte, and whether it closes the frame.
	always_comb begin
		in_frame_d    = in_frame_q;
		char_count_d  = char_count_q;
		sep_count_d   = sep_count_q;
		in_fraction_d = in_fraction_q;
		acc_d         = acc_q;
		held_p_d      = held_p_q;
		held_i_d      = held_i_q;
		finish        = 1'b0;
		accepted      = 1'b0;
		status        = StatusGood;
		count_next    = {1'b0, char_count_q} + {{CountW{1'b0}}, 1'b1};
		sep_next      = (sep_count_q == 2'd3) ? 2'd3 : sep_count_q + 2'd1;

		if (step_in.fire) begin
			if (!in_frame_q) begin
				// Outside a frame only the start mark matters.
				if (step_in.rx_byte == CharCaret) begin
					in_frame_d    = 1'b1;
					char_count_d  = '0;
					sep_count_d   = '0;
					in_fraction_d = 1'b0;
					acc_d         = '0;
					held_p_d      = '0;
					held_i_d      = '0;
				end
			end else if (step_in.rx_byte == CharCr || step_in.rx_byte == CharLf) begin
				finish = 1'b1;
				status = StatusGood;
			end else begin
				accepted = 1'b1;
				case (step_in.rx_byte) inside
					[CharZero:CharNine]: begin
						// acc * 10 + digit, kept to 16 bits; the low nibble is the digit.
						if (!in_fraction_q) begin
							acc_d = {acc_q[GainW-4:0], 3'b000} + {acc_q[GainW-2:0], 1'b0}
								+ {{(GainW-4){1'b0}}, step_in.rx_byte[3:0]};
						end
					end
					CharDot: begin
						in_fraction_d = 1'b1;
					end
					CharComma, CharSpace: begin
						sep_count_d = sep_next;
						if (sep_next == 2'd1) begin
							held_p_d = acc_q;
						end else if (sep_next == 2'd2) begin
							held_i_d = acc_q;
						end
						acc_d         = '0;
						in_fraction_d = 1'b0;
					end
					default: begin
						accepted = 1'b0;
						finish   = 1'b1;
						status   = StatusBadChar;
					end
				endcase

				// Count the accepted byte and close the frame at the length limit.
				if (accepted) begin
					char_count_d = count_next[CountW-1:0];
					if (count_next >= (CountW+1)'(MaxFrame)) begin
						finish = 1'b1;
						status = StatusTooLong;
					end
				end
			end
		end

		if (finish) begin
			in_frame_d = 1'b0;
		end
	end

	// Result word built from the state as it stands after this byte.
	always_comb begin
		result = '0;
		result.valid        = finish;
		result.frame_status = status;
		if (finish && status == StatusGood) begin
			if (sep_count_d != 2'd0) begin
				result.gain_p  = held_p_d;
				result.p_given = 1'b1;
			end
			if (sep_count_d[1]) begin
				result.gain_i  = held_i_d;
				result.i_given = 1'b1;
			end
			if (sep_count_d == 2'd2) begin
				result.gain_d  = acc_d;
				result.d_given = 1'b1;
			end
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			char_count_q  <= '0;
			sep_count_q   <= '0;
			in_fraction_q <= 1'b0;
			acc_q         <= '0;
			held_p_q      <= '0;
			held_i_q      <= '0;
		end else begin
			in_frame_q    <= in_frame_d;
			char_count_q  <= char_count_d;
			sep_count_q   <= sep_count_d;
			in_fraction_q <= in_fraction_d;
			acc_q         <= acc_d;
			held_p_q      <= held_p_d;
			held_i_q      <= held_i_d;
		end
	end

`ifndef SYNTH
	// A frame that reports a result is closed on the next cycle.
	a_close_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |=> !in_frame_q)
		else $error("frame still open after its result");

	// The byte count of an open frame never reaches the limit.
	a_count_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> ({1'b0, char_count_q} < (CountW+1)'(MaxFrame)))
		else $error("byte count reached the frame limit");

	// No result comes out of a byte seen outside a frame.
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> !result.valid)
		else $error("result produced outside a frame");
`endif

endmodule

[hw/rtl/gain_frame_parser_top.sv]
// Top level of the gain frame parser: input byte stage, parse step and result register.
// A closing byte is registered in the input byte stage, then its word in the result register.
// Throughput: one byte per cycle while the result side takes each word as it appears.
// The result register frees the input side whenever it is empty or being drained.
// Reset (arst_n low, asynchronous) empties both stages and closes any open frame.
`timescale 1ns / 1ps
module gain_frame_parser_top (
	input  logic          clk,
	input  logic          arst_n,
	gfp_byte_if.sink      rx,
	gfp_result_if.source  res
);
	import gfp_pkg::*;

	logic         valid_s1;
	logic [7:0]   rx_byte_s1;
	logic         res_valid_q;
	gfp_result_t  res_q;
	gfp_result_t  step_res;
	gfp_step_in_t step_in;
	logic         advance;

	// The pipeline moves whenever the result register is free or being taken.
	assign advance  = !res_valid_q || res.ready;
	assign rx.ready = !valid_s1 || advance;

	assign step_in.fire    = valid_s1 && advance;
	assign step_in.rx_byte = rx_byte_s1;

	// Input byte stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	gfp_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_in (step_in),
		.result  (step_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.valid) begin
			res_q <= step_res;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.frame_status = 2'(res_q.frame_status);
	assign res.gain_p       = res_q.gain_p;
	assign res.gain_i       = res_q.gain_i;
	assign res.gain_d       = res_q.gain_d;
	assign res.p_given      = res_q.p_given;
	assign res.i_given      = res_q.i_given;
	assign res.d_given      = res_q.d_given;

endmodule

[bench/tb_gain_frame_parser_top.sv]
// Self-checking testbench for the gain frame parser: byte stream in, parsed frame words out.
`timescale 1ns / 1ps
module tb_gain_frame_parser_top;
	import gfp_pkg::*;

	// One parsed frame word as it leaves the result channel.
	typedef struct {
		gfp_status_t      status;
		logic [GainW-1:0] gain_p;
		logic [GainW-1:0] gain_i;
		logic [GainW-1:0] gain_d;
		logic             p_given;
		logic             i_given;
		logic             d_given;
	} frame_word_t;

	// Tracks the parser state byte by byte and keeps the frame words still owed.
	class frame_tracker;
		logic              frame_open;
		logic [CountW-1:0] taken;
		logic [1:0]        seps;
		logic              in_frac;
		logic [GainW-1:0]  acc;
		logic [GainW-1:0]  p_hold;
		logic [GainW-1:0]  i_hold;
		frame_word_t       owed_words[$];
		int                errors;

		function new();
			frame_open = 1'b0;
			taken = '0;
			seps = '0;
			in_frac = 1'b0;
			acc = '0;
			p_hold = '0;
			i_hold = '0;
			errors = 0;
		endfunction

		// Closing a frame owes one word; gains count only on a good close.
		function void close_frame(gfp_status_t st);
			frame_word_t w;
			w.status = st;
			w.gain_p = '0;
			w.gain_i = '0;
			w.gain_d = '0;
			w.p_given = 1'b0;
			w.i_given = 1'b0;
			w.d_given = 1'b0;
			if (st == StatusGood) begin
				if (seps >= 2'd1) begin
					w.gain_p = p_hold;
					w.p_given = 1'b1;
				end
				if (seps >= 2'd2) begin
					w.gain_i = i_hold;
					w.i_given = 1'b1;
				end
				if (seps == 2'd2) begin
					w.gain_d = acc;
					w.d_given = 1'b1;
				end
			end
			frame_open = 1'b0;
			owed_words.push_back(w);
		endfunction

		// Called for every byte the parser accepts.
		function void take_byte(logic [7:0] b);
			if (!frame_open) begin
				if (b == CharCaret) begin
					frame_open = 1'b1;
					taken = '0;
					seps = '0;
					in_frac = 1'b0;
					acc = '0;
					p_hold = '0;
					i_hold = '0;
				end
				return;
			end
			if (b == CharCr || b == CharLf) begin
				close_frame(StatusGood);
				return;
			end
			if (b >= CharZero && b <= CharNine) begin
				if (!in_frac)
					acc = acc * GainW'(10) + GainW'(b - CharZero);
			end else if (b == CharDot) begin
				in_frac = 1'b1;
			end else if (b == CharComma || b == CharSpace) begin
				if (seps != 2'd3)
					seps = seps + 2'd1;
				if (seps == 2'd1)
					p_hold = acc;
				else if (seps == 2'd2)
					i_hold = acc;
				acc = '0;
				in_frac = 1'b0;
			end else begin
				close_frame(StatusBadChar);
				return;
			end
			taken = taken + 1'b1;
			if (taken >= MaxFrame)
				close_frame(StatusTooLong);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		// Called for every frame word taken from the parser.
		function void match_word(frame_word_t got);
			frame_word_t want;
			if (owed_words.size() == 0) begin
				$error("frame word with status %0d arrived while none was owed", got.status);
				errors++;
				return;
			end
			want = owed_words.pop_front();
			compare_field("frame_status", want.status, got.status);
			compare_field("gain_p", want.gain_p, got.gain_p);
			compare_field("gain_i", want.gain_i, got.gain_i);
			compare_field("gain_d", want.gain_d, got.gain_d);
			compare_field("p_given", want.p_given, got.p_given);
			compare_field("i_given", want.i_given, got.i_given);
			compare_field("d_given", want.d_given, got.d_given);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   rx_burst;
	bit   res_burst;

	gfp_byte_if   rx();
	gfp_result_if res();

	frame_tracker tracker = new();

	gain_frame_parser_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Per-word wait; now and then a side switches into a stretch with no waits.
	function automatic int draw_wait(inout bit burst);
		if ($urandom_range(0, 47) == 0)
			burst = !burst;
		return burst ? 0 : int'($urandom_range(0, 13));
	endfunction

	// Offers one byte and returns at the falling edge after it was taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = draw_wait(rx_burst);
		if (gap > 0) begin
			rx.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx.valid = 1'b1;
		rx.rx_byte = b;
		do @(posedge clk); while (!rx.ready);
		tracker.take_byte(b);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int k = 0; k < s.len(); k++)
			send_byte(s[k]);
	endtask

	// Builds one random frame: mostly well formed, some overlong, some with a stray byte.
	function automatic void build_frame(ref logic [7:0] q[$]);
		int         kind;
		int         nfields;
		int         ndig;
		int         target;
		int         pos;
		logic [7:0] junk;
		q.delete();
		kind = $urandom_range(0, 9);
		nfields = $urandom_range(1, 4);
		q.push_back(CharCaret);
		for (int f = 0; f < nfields; f++) begin
			ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
			repeat (ndig) q.push_back(CharZero + 8'($urandom_range(0, 9)));
			if ($urandom_range(0, 3) == 0) begin
				q.push_back(CharDot);
				repeat ($urandom_range(0, 3))
					q.push_back(($urandom_range(0, 4) == 0) ? CharDot
						: CharZero + 8'($urandom_range(0, 9)));
			end
			if (f < nfields - 1) begin
				q.push_back($urandom_range(0, 1) ? CharComma : CharSpace);
				if ($urandom_range(0, 5) == 0)
					q.push_back($urandom_range(0, 1) ? CharComma : CharSpace);
			end
		end
		// Pad around the length limit so both sides of it are hit.
		if (kind == 7) begin
			target = $urandom_range(28, 40);
			while (q.size() < target) begin
				case ($urandom_range(0, 5))
					0: begin
						q.push_back(CharComma);
					end
					1: begin
						q.push_back(CharSpace);
					end
					2: begin
						q.push_back(CharDot);
					end
					default: begin
						q.push_back(CharZero + 8'($urandom_range(0, 9)));
					end
				endcase
			end
		end
		q.push_back($urandom_range(0, 1) ? CharCr : CharLf);
		// A byte that is not allowed inside a frame, the start mark among them.
		if (kind == 8) begin
			do junk = 8'($urandom);
			while ((junk >= CharZero && junk <= CharNine) || junk == CharDot ||
				junk == CharComma || junk == CharSpace || junk == CharCr || junk == CharLf);
			if ($urandom_range(0, 3) == 0)
				junk = CharCaret;
			pos = $urandom_range(1, q.size() - 1);
			q.insert(pos, junk);
		end
	endfunction

	// Result side: stalls at random, then checks each word it takes.
	initial begin
		frame_word_t got;
		int          stall;
		res.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = draw_wait(res_burst);
			if (stall > 0) begin
				res.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res.ready = 1'b1;
			do @(posedge clk); while (!res.valid);
			got.status = gfp_status_t'(res.frame_status);
			got.gain_p = res.gain_p;
			got.gain_i = res.gain_i;
			got.gain_d = res.gain_d;
			got.p_given = res.p_given;
			got.i_given = res.i_given;
			got.d_given = res.d_given;
			tracker.match_word(got);
			@(negedge clk);
		end
	end

	// Reset, directed frames, random frames, then drain.
	initial begin
		logic [7:0] frame_q[$];
		logic [7:0] junk;
		int         frame_bytes_sent;
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		frame_bytes_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Extremes outside a frame are dropped.
		send_byte(8'h00);
		send_byte(8'hFF);
		// Integer part wraps to zero, fraction ignored, all three gains given.
		send_text("^65536.9,1 2");
		send_byte(CharCr);
		// Repeated dots, then a start mark inside the frame closes it as bad.
		send_text("^.5..,^");
		// Separators saturate, so the third gain is not given.
		send_text("^9,,, 7");
		send_byte(CharLf);

		while (frame_bytes_sent < 1950) begin
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					do junk = 8'($urandom); while (junk == CharCaret);
					send_byte(junk);
				end
			end
			build_frame(frame_q);
			foreach (frame_q[k]) begin
				send_byte(frame_q[k]);
				frame_bytes_sent++;
			end
		end
		rx.valid = 1'b0;

		while (tracker.owed_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule
